// File: sv/hkst_pkg.sv
// ----------------------------------------------------------------------------
// hkst_pkg
// Shared types and constants for the held key set table.
// ----------------------------------------------------------------------------
package hkst_pkg;

   localparam int unsigned OP_W    = 3;
   localparam int unsigned KEY_W   = 32;
   localparam int unsigned COUNT_W = 6;

   typedef enum logic [OP_W-1:0] {
      OP_QUERY   = 3'd0,
      OP_PRESS   = 3'd1,
      OP_RELEASE = 3'd2,
      OP_TOGGLE  = 3'd3,
      OP_CLEAR   = 3'd4
   } op_code_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_APPLY,
      ST_RD_LAST,
      ST_MOVE,
      ST_FINISH
   } state_type;

endpackage

// File: sv/hkst_ram.sv
// ----------------------------------------------------------------------------
// hkst_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module hkst_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 32
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/held_key_set_table.sv
// ----------------------------------------------------------------------------
// held_key_set_table
// Compact array of held key codes with query, press, release, toggle and
// clear operations, kept in a single synchronous RAM.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | words
//  req     | in        | req_valid/req_ready  | req_operation, req_key_code
//  rsp     | out       | rsp_valid/rsp_ready  | rsp_key_held, rsp_dropped,
//          |           |                      | rsp_held_count
//
// A clear, or a word with key code zero, skips the search; any other word runs
// a linear search through the slot RAM, one read a cycle, and a release that
// moves the last key into the freed slot adds a read and a write of the RAM.
// One word is in work at a time; a new word is taken while a result waits.
// Reset is synchronous and empties the table at once; the RAM is not cleared.
// ----------------------------------------------------------------------------
module held_key_set_table #(
   parameter int unsigned KEY_SLOTS = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [hkst_pkg::OP_W-1:0]          req_operation,
   input  logic [hkst_pkg::KEY_W-1:0]         req_key_code,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_key_held,
   output logic                               rsp_dropped,
   output logic [hkst_pkg::COUNT_W-1:0]       rsp_held_count
);

   localparam int unsigned AW = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
   localparam int unsigned CW = $clog2(KEY_SLOTS + 1);

   hkst_pkg::state_type state_ff, state_in;
   logic [hkst_pkg::OP_W-1:0]    op_ff, op_in;
   logic [hkst_pkg::KEY_W-1:0]   key_ff, key_in;
   logic                         found_ff, found_in;
   logic [AW-1:0]                hit_idx_ff, hit_idx_in;
   logic [CW-1:0]                issue_ff, issue_in;
   logic                         pend_vld_ff, pend_vld_in;
   logic [AW-1:0]                pend_idx_ff, pend_idx_in;
   logic [CW-1:0]                used_ff, used_in;
   logic                         res_held_ff, res_held_in;
   logic                         res_drop_ff, res_drop_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_held_ff, rsp_held_in;
   logic                         rsp_drop_ff, rsp_drop_in;
   logic [hkst_pkg::COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic                         ram_we;
   logic [AW-1:0]                ram_waddr;
   logic [hkst_pkg::KEY_W-1:0]   ram_wdata;
   logic [AW-1:0]                ram_raddr;
   logic [hkst_pkg::KEY_W-1:0]   ram_rdata;

   logic [CW-1:0]                last_cnt;
   logic [AW-1:0]                last_addr;
   logic                         is_press;
   logic                         is_release;
   logic                         hit;
   logic [hkst_pkg::COUNT_W-1:0] count_sat;

   hkst_ram #(
      .WIDTH (hkst_pkg::KEY_W),
      .DEPTH (KEY_SLOTS)
   ) u_slots (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign last_cnt   = used_ff - CW'(1);
   assign last_addr  = last_cnt[AW-1:0];
   assign is_press   = (op_ff == hkst_pkg::OP_PRESS) ||
                       ((op_ff == hkst_pkg::OP_TOGGLE) && !found_ff);
   assign is_release = (op_ff == hkst_pkg::OP_RELEASE) ||
                       ((op_ff == hkst_pkg::OP_TOGGLE) && found_ff);
   assign hit        = pend_vld_ff && (ram_rdata == key_ff);
   assign count_sat  = (32'(used_ff) > 32'd63) ? hkst_pkg::COUNT_W'(63)
                                               : hkst_pkg::COUNT_W'(used_ff);

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      found_in     = found_ff;
      hit_idx_in   = hit_idx_ff;
      issue_in     = issue_ff;
      pend_vld_in  = 1'b0;
      pend_idx_in  = pend_idx_ff;
      used_in      = used_ff;
      res_held_in  = res_held_ff;
      res_drop_in  = res_drop_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_held_in  = rsp_held_ff;
      rsp_drop_in  = rsp_drop_ff;
      rsp_count_in = rsp_count_ff;
      req_ready    = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = used_ff[AW-1:0];
      ram_wdata    = key_ff;
      ram_raddr    = issue_ff[AW-1:0];

      case (state_ff)
         hkst_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in       = req_operation;
               key_in      = req_key_code;
               found_in    = 1'b0;
               issue_in    = '0;
               res_held_in = 1'b0;
               res_drop_in = 1'b0;
               if (req_operation == hkst_pkg::OP_CLEAR) begin
                  used_in  = '0;
                  state_in = hkst_pkg::ST_FINISH;
               end else if (req_key_code == '0) begin
                  state_in = hkst_pkg::ST_FINISH;
               end else begin
                  state_in = hkst_pkg::ST_SCAN;
               end
            end
         end
         hkst_pkg::ST_SCAN: begin
            if (hit) begin
               found_in   = 1'b1;
               hit_idx_in = pend_idx_ff;
               state_in   = hkst_pkg::ST_APPLY;
            end else if (issue_ff < used_ff) begin
               pend_vld_in = 1'b1;
               pend_idx_in = issue_ff[AW-1:0];
               issue_in    = issue_ff + CW'(1);
            end else if (!pend_vld_ff) begin
               state_in = hkst_pkg::ST_APPLY;
            end
         end
         hkst_pkg::ST_APPLY: begin
            state_in = hkst_pkg::ST_FINISH;
            if (is_press) begin
               if (found_ff) begin
                  res_held_in = 1'b1;
               end else if (used_ff == CW'(KEY_SLOTS)) begin
                  res_drop_in = 1'b1;
               end else begin
                  ram_we      = 1'b1;
                  used_in     = used_ff + CW'(1);
                  res_held_in = 1'b1;
               end
            end else if (is_release) begin
               if (found_ff) begin
                  if (hit_idx_ff == last_addr) begin
                     used_in = last_cnt;
                  end else begin
                     state_in = hkst_pkg::ST_RD_LAST;
                  end
               end
            end else begin
               res_held_in = found_ff;
            end
         end
         hkst_pkg::ST_RD_LAST: begin
            ram_raddr = last_addr;
            state_in  = hkst_pkg::ST_MOVE;
         end
         hkst_pkg::ST_MOVE: begin
            ram_we    = 1'b1;
            ram_waddr = hit_idx_ff;
            ram_wdata = ram_rdata;
            used_in   = last_cnt;
            state_in  = hkst_pkg::ST_FINISH;
         end
         hkst_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_held_in  = res_held_ff;
               rsp_drop_in  = res_drop_ff;
               rsp_count_in = count_sat;
               state_in     = hkst_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = hkst_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hkst_pkg::ST_IDLE;
         used_ff      <= '0;
         pend_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         pend_vld_ff  <= pend_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff        <= op_in;
      key_ff       <= key_in;
      found_ff     <= found_in;
      hit_idx_ff   <= hit_idx_in;
      issue_ff     <= issue_in;
      pend_idx_ff  <= pend_idx_in;
      res_held_ff  <= res_held_in;
      res_drop_ff  <= res_drop_in;
      rsp_held_ff  <= rsp_held_in;
      rsp_drop_ff  <= rsp_drop_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_key_held   = rsp_held_ff;
   assign rsp_dropped    = rsp_drop_ff;
   assign rsp_held_count = rsp_count_ff;

   a_used_in_range: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CW'(KEY_SLOTS))
      else $error("held count exceeds the number of slots");

   a_drop_not_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_drop_ff && rsp_held_ff))
      else $error("a dropped press reports the key as held");

   a_pend_in_scan: assert property (@(posedge clock) disable iff (reset)
      pend_vld_ff |-> (state_ff == hkst_pkg::ST_SCAN))
      else $error("slot read pending outside the search");

   a_count_stable_in_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == hkst_pkg::ST_SCAN) |=> $stable(used_ff))
      else $error("held count changed during the search");

   a_no_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == hkst_pkg::ST_APPLY || state_ff == hkst_pkg::ST_MOVE))
      else $error("slot RAM written outside the update states");

endmodule
